[hdl/odfc_pkg.sv]
// ----------------------------------------------------------------------------
// odfc_pkg
// Shared types and constants of the oscillator DAC frequency correction core.
// ----------------------------------------------------------------------------
package odfc_pkg;

    // Default parameter values
    localparam int STEP_SHIFT_DEF = 10;
    localparam int DAC_WIDTH_DEF  = 16;

    // Fixed field widths
    localparam int FREQ_W  = 64;
    localparam int RANGE_W = 32;
    localparam int CODE_W  = 16;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 64;

    // Shared divider: the dividend holds the full frequency times code product
    localparam int                NUM_W    = FREQ_W + RANGE_W;
    localparam int                CNT_W    = $clog2(NUM_W);
    localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(NUM_W - 1);

    // Direction codes
    typedef enum logic [1:0] {
        DIR_EQUAL = 2'd0,
        DIR_RAISE = 2'd1,
        DIR_LOWER = 2'd2
    } t_dir;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic fill_ones;
        logic mul_lo;
        logic mul_hi;
        logic ld_div_a;
        logic div_step;
        logic rnd_a;
        logic ld_div_b;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic step_zero;
        logic meas_zero;
        logic div_last;
    } t_sts;

endpackage

[hdl/odfc_dpath.sv]
// ----------------------------------------------------------------------------
// odfc_dpath
// Datapath: step size, split 64x32 product, shared restoring divider with
// round-half-up, and the final code update.
// ----------------------------------------------------------------------------
module odfc_dpath #(
    parameter int STEP_SHIFT = odfc_pkg::STEP_SHIFT_DEF,
    parameter int DAC_WIDTH  = odfc_pkg::DAC_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  odfc_pkg::t_cmd               i_cmd,
    output odfc_pkg::t_sts               o_sts,
    input  logic [odfc_pkg::FREQ_W-1:0]  i_target,
    input  logic [odfc_pkg::RANGE_W-1:0] i_range,
    input  logic [odfc_pkg::FREQ_W-1:0]  i_meas,
    input  logic [odfc_pkg::CODE_W-1:0]  i_dac,
    output logic [odfc_pkg::CODE_W-1:0]  o_new_dac,
    output logic [1:0]                   o_dir
);

    localparam int FW = odfc_pkg::FREQ_W;
    localparam int RW = odfc_pkg::RANGE_W;
    localparam int NW = odfc_pkg::NUM_W;
    localparam int CW = odfc_pkg::CNT_W;

    logic [FW-1:0]        r_meas;
    logic [DAC_WIDTH-1:0] r_dac;
    logic [RW-1:0]        r_step;
    logic [FW-1:0]        r_plo;
    logic [FW-1:0]        r_phi;
    logic [NW-1:0]        r_num;
    logic [FW-1:0]        r_den;
    logic [FW-1:0]        r_rem;
    logic [DAC_WIDTH-1:0] r_quo;
    logic [CW-1:0]        r_cnt;
    odfc_pkg::t_dir       r_dir;
    logic [DAC_WIDTH-1:0] r_out;

    logic [RW:0]          step_sum;
    logic [RW-1:0]        n_step;
    logic [RW-1:0]        dac32;
    logic [FW:0]          rem_sh;
    logic                 ge;
    logic [FW:0]          rem_sub;
    logic                 rnd;
    logic [DAC_WIDTH-1:0] shift_amt;
    logic [DAC_WIDTH-1:0] n_out;
    logic                 meas_lt;
    logic                 meas_gt;
    logic [FW-1:0]        diff;

    // Round-half-up step per DAC count
    assign step_sum = {1'b0, i_range} + ((RW+1)'(1) << (STEP_SHIFT - 1));
    assign n_step   = RW'(step_sum >> STEP_SHIFT);

    assign dac32 = RW'(r_dac);

    // One restoring divide step
    assign rem_sh  = {r_rem, r_num[NW-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    // Round half up on the final remainder
    assign rnd       = (r_rem >= (r_den - r_rem));
    assign shift_amt = r_quo + DAC_WIDTH'(rnd);

    assign meas_lt = (r_meas < i_target);
    assign meas_gt = (r_meas > i_target);
    assign diff    = meas_lt ? (i_target - r_meas) : (r_meas - i_target);

    always_comb begin
        unique case (r_dir)
            odfc_pkg::DIR_RAISE: n_out = r_dac + shift_amt;
            odfc_pkg::DIR_LOWER: n_out = r_dac - shift_amt;
            default:             n_out = r_dac;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_meas <= i_meas;
            r_dac  <= DAC_WIDTH'(i_dac);
            r_step <= n_step;
        end
        if (i_cmd.fill_ones) begin
            r_dac <= '1;
        end
        if (i_cmd.mul_lo) begin
            r_plo <= FW'(i_target[RW-1:0] * dac32);
        end
        if (i_cmd.mul_hi) begin
            r_phi <= FW'(i_target[FW-1:RW] * dac32);
        end
        if (i_cmd.ld_div_a) begin
            r_num <= {{(NW-FW){1'b0}}, r_plo} + {r_phi, {(NW-FW){1'b0}}};
            r_den <= r_meas;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= ge ? FW'(rem_sub) : FW'(rem_sh);
            r_quo <= {r_quo[DAC_WIDTH-2:0], ge};
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.rnd_a) begin
            r_dac <= shift_amt;
        end
        if (i_cmd.ld_div_b) begin
            r_num <= {{(NW-FW){1'b0}}, diff};
            r_den <= (r_step == '0) ? FW'(1) : FW'(r_step);
            r_rem <= '0;
            r_cnt <= '0;
            if (meas_lt) begin
                r_dir <= odfc_pkg::DIR_RAISE;
            end else if (meas_gt) begin
                r_dir <= odfc_pkg::DIR_LOWER;
            end else begin
                r_dir <= odfc_pkg::DIR_EQUAL;
            end
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_sts.step_zero = (r_step == '0);
    assign o_sts.meas_zero = (r_meas == '0);
    assign o_sts.div_last  = (r_cnt == odfc_pkg::DIV_LAST);

    assign o_new_dac = odfc_pkg::CODE_W'(r_out);
    assign o_dir     = r_dir;

endmodule

[hdl/odfc_ctrl.sv]
// ----------------------------------------------------------------------------
// odfc_ctrl
// Sequencer: walks one item through any rescale, correction divide and update.
// ----------------------------------------------------------------------------
module odfc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output logic           o_done,
    output odfc_pkg::t_cmd o_cmd,
    input  odfc_pkg::t_sts i_sts
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SETUP  = 10'b00_0000_0010,
        S_MUL_LO = 10'b00_0000_0100,
        S_MUL_HI = 10'b00_0000_1000,
        S_ACC    = 10'b00_0001_0000,
        S_DIV_A  = 10'b00_0010_0000,
        S_RND_A  = 10'b00_0100_0000,
        S_PREP   = 10'b00_1000_0000,
        S_DIV_B  = 10'b01_0000_0000,
        S_FIN    = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                priority if (i_sts.step_zero && i_sts.meas_zero) begin
                    o_cmd.fill_ones = 1'b1;
                    n_state         = S_PREP;
                end else if (i_sts.step_zero) begin
                    n_state = S_MUL_LO;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.ld_div_a = 1'b1;
                n_state        = S_DIV_A;
            end
            S_DIV_A: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_RND_A;
                end
            end
            S_RND_A: begin
                o_cmd.rnd_a = 1'b1;
                n_state     = S_PREP;
            end
            S_PREP: begin
                o_cmd.ld_div_b = 1'b1;
                n_state        = S_DIV_B;
            end
            S_DIV_B: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.finish;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

[hdl/oscillator_dac_frequency_correction_core.sv]
// ----------------------------------------------------------------------------
// oscillator_dac_frequency_correction_core
// Corrects a tuning DAC code from a measured oscillator frequency.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in one item (measured frequency and
// current DAC code). The corrected code and direction are valid on the result
// ports while o_done is high for exactly one cycle; there is no back pressure, so
// capture them on that cycle. An item goes straight to the correction divide
// when the rounded step is nonzero, or when the step rounds to zero but the
// measurement is zero (the code is then simply filled with ones). When the
// step rounds to zero and the measurement is nonzero, the code is first
// rescaled by target/measured. busy drops on the o_done cycle, so a new item
// may be accepted right then. The correction, and the rescale where it runs,
// use the shared restoring divider, which retires one quotient bit per cycle
// over a 96-bit dividend. Registers: target_frequency at byte 0x0, tuning_range
// at byte 0x8 (low 32 bits); write them only while busy is low.
// ----------------------------------------------------------------------------
module oscillator_dac_frequency_correction_core #(
    parameter int STEP_SHIFT = odfc_pkg::STEP_SHIFT_DEF,
    parameter int DAC_WIDTH  = odfc_pkg::DAC_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [odfc_pkg::ADDR_W-1:0]   paddr,
    input  logic [odfc_pkg::DATA_W-1:0]   pwdata,
    output logic [odfc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // Item input
    input  logic                          start,
    output logic                          busy,
    input  logic [odfc_pkg::FREQ_W-1:0]   i_measured_frequency,
    input  logic [odfc_pkg::CODE_W-1:0]   i_dac_code,
    // Result output
    output logic                          o_done,
    output logic [odfc_pkg::CODE_W-1:0]   o_new_dac_code,
    output logic [1:0]                    o_direction
);

    logic [odfc_pkg::FREQ_W-1:0]  r_target;
    logic [odfc_pkg::RANGE_W-1:0] r_range;
    logic                         cfg_wr;
    logic                         reg_sel;
    odfc_pkg::t_cmd               cmd;
    odfc_pkg::t_sts               sts;

    // Registers are 64 bits apart: address bit 3 picks the register
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_range  <= '0;
        end else if (cfg_wr) begin
            if (reg_sel) begin
                r_range <= pwdata[odfc_pkg::RANGE_W-1:0];
            end else begin
                r_target <= pwdata;
            end
        end
    end

    assign prdata = reg_sel ? odfc_pkg::DATA_W'(r_range) : r_target;

    // Sequencer
    odfc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // Arithmetic
    odfc_dpath #(
        .STEP_SHIFT (STEP_SHIFT),
        .DAC_WIDTH  (DAC_WIDTH)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_target  (r_target),
        .i_range   (r_range),
        .i_meas    (i_measured_frequency),
        .i_dac     (i_dac_code),
        .o_new_dac (o_new_dac_code),
        .o_dir     (o_direction)
    );

    // An accepted item keeps the core busy on the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A result only follows a busy cycle, and the core is free on it
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe outside item completion");

    // Results never pulse back to back
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    // Direction carries a defined code on every result
    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_direction == odfc_pkg::DIR_EQUAL ||
                    o_direction == odfc_pkg::DIR_RAISE ||
                    o_direction == odfc_pkg::DIR_LOWER))
        else $error("undefined direction code on result");

endmodule

[bench/tb_oscillator_dac_frequency_correction_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_oscillator_dac_frequency_correction_core
// Self-checking bench for the DAC frequency correction core. It programs the
// target and tuning range over APB and reads them back. It runs a table of
// directed corner cases, then randomized phases with items clustered around
// the target. Results are checked against typed rows or the correction model.
// ----------------------------------------------------------------------------
module tb_oscillator_dac_frequency_correction_core;

    localparam int          STEP_SHIFT = odfc_pkg::STEP_SHIFT_DEF;
    localparam int          DAC_WIDTH  = odfc_pkg::DAC_WIDTH_DEF;
    localparam logic [63:0] DAC_MASK   = (64'd1 << DAC_WIDTH) - 64'd1;

    // Register byte addresses (8-byte pitch, target is 64 bits wide)
    localparam logic [odfc_pkg::ADDR_W-1:0] REG_TARGET = 4'h0;
    localparam logic [odfc_pkg::ADDR_W-1:0] REG_TUNING = 4'h8;

    localparam int NUM_ROWS   = 22;
    localparam int NUM_PHASES = 19;
    localparam int PHASE_LEN  = 50;

    // One corrected code as the core reports it
    typedef struct packed {
        logic [odfc_pkg::CODE_W-1:0] code;
        odfc_pkg::t_dir              dir;
    } t_correction;

    // One row of the directed table. set_cfg reprograms both registers before
    // the item; typed rows carry their expected result, the rest go through
    // the correction model.
    typedef struct packed {
        bit                           set_cfg;
        logic [odfc_pkg::FREQ_W-1:0]  target;
        logic [odfc_pkg::RANGE_W-1:0] tuning;
        logic [odfc_pkg::FREQ_W-1:0]  meas;
        logic [odfc_pkg::CODE_W-1:0]  dac;
        bit                           typed;
        logic [odfc_pkg::CODE_W-1:0]  want_code;
        odfc_pkg::t_dir               want_dir;
    } t_dir_row;

    localparam logic [63:0] F_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    t_dir_row directed_rows [NUM_ROWS] = '{
        // registers still at reset: zero step, zero measurement gives all ones
        '{1'b0, 64'd0, 32'd0, 64'd0, 16'h1234, 1'b1, 16'hFFFF, odfc_pkg::DIR_EQUAL},
        // registers at reset, rescale to zero then lower by the full error
        '{1'b0, 64'd0, 32'd0, 64'd5, 16'd1234, 1'b1, 16'hFFFB, odfc_pkg::DIR_LOWER},
        // on target
        '{1'b1, 64'd1000, 32'd1024, 64'd1000, 16'h1234, 1'b1, 16'h1234,
          odfc_pkg::DIR_EQUAL},
        // step of 8: plain raise and lower
        '{1'b1, 64'd1000, 32'd8192, 64'd920, 16'd100, 1'b1, 16'd110, odfc_pkg::DIR_RAISE},
        '{1'b0, 64'd0, 32'd0, 64'd1080, 16'd100, 1'b1, 16'd90, odfc_pkg::DIR_LOWER},
        // half a step rounds up, just under half rounds down
        '{1'b0, 64'd0, 32'd0, 64'd996, 16'd100, 1'b1, 16'd101, odfc_pkg::DIR_RAISE},
        '{1'b0, 64'd0, 32'd0, 64'd997, 16'd100, 1'b1, 16'd100, odfc_pkg::DIR_RAISE},
        '{1'b0, 64'd0, 32'd0, 64'd1004, 16'd100, 1'b1, 16'd99, odfc_pkg::DIR_LOWER},
        // code wraps over the top and under zero
        '{1'b1, 64'd10, 32'd1024, 64'd8, 16'hFFFF, 1'b1, 16'h0001, odfc_pkg::DIR_RAISE},
        '{1'b0, 64'd0, 32'd0, 64'd12, 16'h0000, 1'b1, 16'hFFFE, odfc_pkg::DIR_LOWER},
        // zero measurement with a nonzero step is just a large error
        '{1'b0, 64'd0, 32'd0, 64'd0, 16'h00FF, 1'b1, 16'h0109, odfc_pkg::DIR_RAISE},
        // last range that rounds the step to zero, then first that does not
        '{1'b1, 64'd100, 32'd511, 64'd50, 16'd10, 1'b1, 16'd70, odfc_pkg::DIR_RAISE},
        '{1'b1, 64'd100, 32'd512, 64'd50, 16'd10, 1'b1, 16'd60, odfc_pkg::DIR_RAISE},
        // rescale rounding: 1.5 goes to 2, 0.5 goes to 1
        '{1'b1, 64'd3, 32'd0, 64'd2, 16'd1, 1'b1, 16'd3, odfc_pkg::DIR_RAISE},
        '{1'b0, 64'd0, 32'd0, 64'd6, 16'd1, 1'b1, 16'hFFFE, odfc_pkg::DIR_LOWER},
        // zero measurement with a zero step fills ones, then the raise on top
        '{1'b1, 64'd5, 32'd0, 64'd0, 16'd7, 1'b1, 16'h0004, odfc_pkg::DIR_RAISE},
        // full-scale target: rescale by one, then by the whole target
        '{1'b1, F_MAX, 32'd0, F_MAX, 16'h8001, 1'b1, 16'h8001, odfc_pkg::DIR_EQUAL},
        '{1'b0, 64'd0, 32'd0, 64'd1, 16'hFFFF, 1'b0, 16'd0, odfc_pkg::DIR_EQUAL},
        // widest step with the largest possible error both ways, then large mixed values
        '{1'b1, F_MAX, 32'hFFFF_FFFF, 64'd0, 16'hABCD, 1'b0, 16'd0, odfc_pkg::DIR_EQUAL},
        '{1'b1, 64'd0, 32'hFFFF_FFFF, F_MAX, 16'h5A5A, 1'b0, 16'd0, odfc_pkg::DIR_EQUAL},
        '{1'b1, 64'h8000_0000_0000_0000, 32'h0012_3456, 64'h7FFF_FFFF_0000_0001,
          16'h0F0F, 1'b0, 16'd0, odfc_pkg::DIR_EQUAL},
        '{1'b1, 64'h1234_5678_9ABC_DEF0, 32'd300, 64'h0FED_CBA9_8765_4321,
          16'hC3C3, 1'b0, 16'd0, odfc_pkg::DIR_EQUAL}
    };

    // DUT connections; the inputs are known from time zero
    logic                           i_clk                = 1'b0;
    logic                           i_rst_n              = 1'b0;
    logic                           psel                 = 1'b0;
    logic                           penable              = 1'b0;
    logic                           pwrite               = 1'b0;
    logic [odfc_pkg::ADDR_W-1:0]    paddr                = '0;
    logic [odfc_pkg::DATA_W-1:0]    pwdata               = '0;
    logic [odfc_pkg::DATA_W-1:0]    prdata;
    logic                           pready;
    logic                           start                = 1'b0;
    logic                           busy;
    logic [odfc_pkg::FREQ_W-1:0]    i_measured_frequency = '0;
    logic [odfc_pkg::CODE_W-1:0]    i_dac_code           = '0;
    logic                           o_done;
    logic [odfc_pkg::CODE_W-1:0]    o_new_dac_code;
    logic [1:0]                     o_direction;

    // Mirror of the core's registers, as last written
    logic [odfc_pkg::FREQ_W-1:0]    cfg_target = '0;
    logic [odfc_pkg::RANGE_W-1:0]   cfg_tuning = '0;

    // Corrections owed by the core, oldest first
    t_correction                    pending_corrections [$];
    int unsigned                    fail_count = 0;

    oscillator_dac_frequency_correction_core i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .start                (start),
        .busy                 (busy),
        .i_measured_frequency (i_measured_frequency),
        .i_dac_code           (i_dac_code),
        .o_done               (o_done),
        .o_new_dac_code       (o_new_dac_code),
        .o_direction          (o_direction)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Correction model: rounded step, optional rescale by target/measured when
    // the step rounds to zero, then add or subtract the rounded error/step.
    function automatic t_correction predict_correction(
            input logic [odfc_pkg::FREQ_W-1:0] meas,
            input logic [odfc_pkg::CODE_W-1:0] dac_in);
        logic [63:0]  step;
        logic [63:0]  code;
        logic [63:0]  err;
        logic [63:0]  shift_q;
        logic [63:0]  shift_r;
        logic [127:0] prod;
        logic [127:0] quo;
        logic [127:0] rem;
        t_correction  res;
        step    = 64'(({1'b0, cfg_tuning} + (33'd1 << (STEP_SHIFT - 1))) >> STEP_SHIFT);
        code    = 64'(dac_in) & DAC_MASK;
        res.dir = odfc_pkg::DIR_EQUAL;
        if (step == 64'd0) begin
            // Step too fine to resolve: use one count, rescale or fill the code
            step = 64'd1;
            if (meas == 64'd0) begin
                code = DAC_MASK;
            end else begin
                prod = 128'(cfg_target) * 128'(code);
                quo  = prod / 128'(meas);
                rem  = prod % 128'(meas);
                if (rem >= 128'(meas) - rem) begin
                    quo = quo + 128'd1;
                end
                code = quo[63:0] & DAC_MASK;
            end
        end
        if (meas != cfg_target) begin
            err     = (meas < cfg_target) ? cfg_target - meas : meas - cfg_target;
            shift_q = err / step;
            shift_r = err % step;
            if (shift_r >= step - shift_r) begin
                shift_q = shift_q + 64'd1;
            end
            if (meas < cfg_target) begin
                code    = (code + shift_q) & DAC_MASK;
                res.dir = odfc_pkg::DIR_RAISE;
            end else begin
                code    = (code - shift_q) & DAC_MASK;
                res.dir = odfc_pkg::DIR_LOWER;
            end
        end
        res.code = code[odfc_pkg::CODE_W-1:0];
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Idle length before an item: none when steady, else mostly none or short, now and then long
    // enough to land anywhere inside an item with a rescale.
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50) begin
            return 0;
        end else if (roll < 80) begin
            return $urandom_range(1, 3);
        end else if (roll < 93) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(21, 250);
    endfunction

    // One APB transfer: wait for a clock edge, then setup, access, wait for pready.
    task automatic apb_access(input bit wr, input logic [odfc_pkg::ADDR_W-1:0] addr,
                              input logic [odfc_pkg::DATA_W-1:0] wdata,
                              output logic [odfc_pkg::DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain the core, write both registers and read them back. Junk in the
    // upper half of the tuning write must be dropped by the core.
    task automatic program_correction(input logic [odfc_pkg::FREQ_W-1:0] target,
                                      input logic [odfc_pkg::RANGE_W-1:0] tuning,
                                      input logic [31:0] junk);
        logic [odfc_pkg::DATA_W-1:0] rd;
        start <= 1'b0;
        while (pending_corrections.size() != 0 || busy) @(posedge i_clk);
        apb_access(1'b1, REG_TARGET, target, rd);
        apb_access(1'b1, REG_TUNING, {junk, tuning}, rd);
        cfg_target = target;
        cfg_tuning = tuning;
        apb_access(1'b0, REG_TARGET, '0, rd);
        if (rd !== 64'(target)) begin
            $error("target_frequency readback: expected %h, got %h", target, rd);
            fail_count++;
        end
        apb_access(1'b0, REG_TUNING, '0, rd);
        if (rd !== 64'(tuning)) begin
            $error("tuning_range readback: expected %h, got %h", 64'(tuning), rd);
            fail_count++;
        end
    endtask

    // Present an item and hold it until the core takes it; record what the
    // core owes for it. Call at a clock edge; returns at the accepting edge
    // with start still high.
    task automatic send_item(input logic [odfc_pkg::FREQ_W-1:0] meas,
                             input logic [odfc_pkg::CODE_W-1:0] dac,
                             input bit typed, input t_correction want);
        start                <= 1'b1;
        i_measured_frequency <= meas;
        i_dac_code           <= dac;
        do @(posedge i_clk); while (busy);
        pending_corrections.push_back(typed ? want : predict_correction(meas, dac));
    endtask

    // Check every result on the cycle o_done marks it
    always @(posedge i_clk) begin : result_check
        t_correction exp_r;
        if (i_rst_n && o_done) begin
            if (pending_corrections.size() == 0) begin
                $error("result with nothing pending: new_dac_code %h direction %0d",
                       o_new_dac_code, o_direction);
                fail_count++;
            end else begin
                exp_r = pending_corrections.pop_front();
                if (o_new_dac_code !== exp_r.code) begin
                    $error("new_dac_code: expected %h, got %h", exp_r.code, o_new_dac_code);
                    fail_count++;
                end
                if (o_direction !== exp_r.dir) begin
                    $error("direction: expected %0d, got %0d", exp_r.dir, o_direction);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [odfc_pkg::FREQ_W-1:0]  target;
        logic [odfc_pkg::RANGE_W-1:0] tuning;
        logic [odfc_pkg::FREQ_W-1:0]  meas;
        logic [odfc_pkg::FREQ_W-1:0]  delta;
        logic [odfc_pkg::CODE_W-1:0]  dac;
        int unsigned                  gap;
        bit                           steady;

        // Hold reset, then release it once for good
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: corners first, registers untouched for the first rows
        foreach (directed_rows[r]) begin
            if (directed_rows[r].set_cfg) begin
                program_correction(directed_rows[r].target, directed_rows[r].tuning,
                                   $urandom);
            end
            gap = pick_gap(1'b0);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            send_item(directed_rows[r].meas, directed_rows[r].dac, directed_rows[r].typed,
                      '{directed_rows[r].want_code, directed_rows[r].want_dir});
        end

        // Random phases: fresh registers each phase, items mostly near target
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0:       target = '0;
                1:       target = F_MAX;
                2:       target = rand64();
                3:       target = 64'($urandom_range(0, 32'hF_FFFF));
                default: target = 64'($urandom);
            endcase
            // Force the extremes on the first phases, then pick freely; about five
            // in twelve of the free picks round the step down to zero.
            case ((ph < 2) ? ph : $urandom_range(2, 7))
                0:       tuning = '0;
                1:       tuning = 32'hFFFF_FFFF;
                2, 3:    tuning = $urandom_range(0, 511);
                4:       tuning = $urandom_range(0, 1) ? 32'd511 : 32'd512;
                5:       tuning = $urandom;
                default: tuning = $urandom_range(512, 200000);
            endcase
            program_correction(target, tuning, $urandom);
            steady = ($urandom_range(0, 3) == 0);

            for (int n = 0; n < PHASE_LEN; n++) begin
                // Error spans many scales: shift a random word down by 0..31
                delta = 64'($urandom) >> $urandom_range(0, 31);
                case ($urandom_range(0, 9))
                    0:       meas = target;
                    1:       meas = rand64();
                    2:       meas = '0;
                    3:       meas = F_MAX;
                    4:       meas = 64'($urandom);
                    5, 6:    meas = target - delta;
                    default: meas = target + delta;
                endcase
                case ($urandom_range(0, 9))
                    0:       dac = '0;
                    1:       dac = '1;
                    default: dac = odfc_pkg::CODE_W'($urandom);
                endcase
                gap = pick_gap(steady);
                if (gap != 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                send_item(meas, dac, 1'b0, '0);
            end
        end

        // Drop start, wait out the last result, then a short tail
        start <= 1'b0;
        while (pending_corrections.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("oscillator_dac_frequency_correction_core regression: pass");
        end else begin
            $display("oscillator_dac_frequency_correction_core regression: fail");
        end
        $finish;
    end

    // Hang guard: well past the slowest legal run
    initial begin : watchdog
        #15_000_000;
        $display("oscillator_dac_frequency_correction_core regression: fail");
        $finish;
    end

endmodule

[files.f]
hdl/odfc_pkg.sv
hdl/odfc_dpath.sv
hdl/odfc_ctrl.sv
hdl/oscillator_dac_frequency_correction_core.sv
bench/tb_oscillator_dac_frequency_correction_core.sv
